>>> rtl/core/fctl_pkg.sv
// Package for the APNG frame-control decoder: field widths, codes,
// register indexes and the word that travels down the divider chain.
// No dependencies.
package fctl_pkg;

	// Widths of the fields and configuration registers.
	localparam int FIELD_W = 32;
	localparam int DIM_W   = 31;
	localparam int DELAY_W = 16;
	localparam int CODE_W  = 8;
	localparam int RATE_W  = 16;
	localparam int REG_IDX_W = 2;

	// Dividend of the duration division: numerator times ticks plus half
	// the denominator stays below 2^33, so the quotient has 33 bits.
	localparam int DVD_W  = 33;
	localparam int QUOT_W = DVD_W;

	localparam logic [DVD_W-1:0]   TICKS_PER_SEC = 33'd100000;
	localparam logic [DELAY_W-1:0] DEFAULT_DEN   = 16'd100;
	localparam logic [DIM_W-1:0]   DURATION_MAX  = 31'h7FFF_FFFF;
	localparam logic [RATE_W-1:0]  FALLBACK_RESET = 16'd15;

	// Dispose and blend codes.
	localparam logic [CODE_W-1:0] DISPOSE_BACKGROUND = 8'd1;
	localparam logic [CODE_W-1:0] DISPOSE_PREVIOUS   = 8'd2;
	localparam logic [CODE_W-1:0] BLEND_SOURCE       = 8'd0;

	// Status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_MAX_RATE     = 2'd2,
		REG_FALLBACK     = 2'd3
	} reg_index_t;

	// Configuration as seen by the front stages.
	typedef struct packed {
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
		logic [RATE_W-1:0] max_rate_limit;
		logic [RATE_W-1:0] fallback_rate;
	} cfg_t;

	// Word handed from cell to cell: frame verdict plus division state.
	typedef struct packed {
		logic               status;
		logic               key_frame;
		logic               div_zero;
		logic [DELAY_W-1:0] divisor;
		logic [DELAY_W-1:0] rem;
		logic [DVD_W-1:0]   dvd;
		logic [QUOT_W-1:0]  quot;
	} div_word_t;

endpackage

>>> rtl/core/fctl_intf.sv
// Channel interfaces of the APNG frame-control decoder: the chunk input
// and the result output, each with valid, ready and payload.
// Depends on fctl_pkg.
interface fctl_chunk_if import fctl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [FIELD_W-1:0]   frame_sequence;
	logic [FIELD_W-1:0]   frame_width;
	logic [FIELD_W-1:0]   frame_height;
	logic [FIELD_W-1:0]   offset_x;
	logic [FIELD_W-1:0]   offset_y;
	logic [DELAY_W-1:0]   delay_numerator;
	logic [DELAY_W-1:0]   delay_denominator;
	logic [CODE_W-1:0]    dispose_kind;
	logic [CODE_W-1:0]    blend_kind;

	modport source(
		output valid, frame_sequence, frame_width, frame_height, offset_x, offset_y,
		output delay_numerator, delay_denominator, dispose_kind, blend_kind,
		input  ready
	);
	modport sink(
		input  valid, frame_sequence, frame_width, frame_height, offset_x, offset_y,
		input  delay_numerator, delay_denominator, dispose_kind, blend_kind,
		output ready
	);
endinterface

interface fctl_result_if import fctl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic             key_frame;
	logic [DIM_W-1:0] duration_ticks;

	modport source(output valid, status, key_frame, duration_ticks, input ready);
	modport sink(input valid, status, key_frame, duration_ticks, output ready);
endinterface

>>> rtl/core/fctl_front.sv
// Front stages of the frame-control decoder: geometry and key-frame verdict,
// rate test and the dividend and divisor of the duration division.
// Depends on fctl_pkg and fctl_chunk_if.
module fctl_front import fctl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	fctl_chunk_if.sink      chunk,
	output logic            down_valid,
	output div_word_t       down_word,
	input  logic            down_ready
);

	logic [FIELD_W-1:0] iw32;
	logic [FIELD_W-1:0] ih32;
	logic               full_frame;
	logic               bad_rect;
	logic               key_c;
	logic [DELAY_W-1:0] den_eff;
	logic [RATE_W:0]    lim_p1;

	logic               v_s1;
	logic               invalid_s1;
	logic               key_s1;
	logic               num_zero_s1;
	logic [DELAY_W-1:0] den_s1;
	logic [DVD_W-1:0]   prod_s1;
	logic [DVD_W-1:0]   scaled_s1;

	logic               too_fast;
	logic               use_fallback;
	logic [DELAY_W-1:0] divisor_c;
	logic [DVD_W-1:0]   dividend_c;

	logic               v_s2;
	div_word_t          word_s2;
	logic               ready_s1;
	logic               ready_s2;

	// Each stage takes a word when it is empty or its word moves on.
	assign ready_s2    = !v_s2 || down_ready;
	assign ready_s1    = !v_s1 || ready_s2;
	assign chunk.ready = ready_s1;

	// Geometry: a full frame covers the canvas at offset zero, anything
	// else must be a later frame lying inside the canvas.
	always_comb begin
		iw32 = {1'b0, cfg.image_width};
		ih32 = {1'b0, cfg.image_height};
		full_frame = (chunk.frame_width == iw32) && (chunk.frame_height == ih32) &&
			(chunk.offset_x == '0) && (chunk.offset_y == '0);
		bad_rect = (chunk.frame_sequence == '0) ||
			(chunk.offset_x >= iw32) || (chunk.frame_width > iw32 - chunk.offset_x) ||
			(chunk.offset_y >= ih32) || (chunk.frame_height > ih32 - chunk.offset_y);
		key_c = full_frame && ((chunk.dispose_kind == DISPOSE_BACKGROUND) ||
			((chunk.frame_sequence == '0) && (chunk.dispose_kind == DISPOSE_PREVIOUS)) ||
			(chunk.blend_kind == BLEND_SOURCE));
		den_eff = (chunk.delay_denominator == '0) ? DEFAULT_DEN : chunk.delay_denominator;
		lim_p1  = {1'b0, cfg.max_rate_limit} + {{RATE_W{1'b0}}, 1'b1};
	end

	// First stage: verdict, the rate bound (limit+1)*num and num*ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= chunk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && chunk.valid) begin
			invalid_s1  <= !full_frame && bad_rect;
			key_s1      <= key_c;
			num_zero_s1 <= (chunk.delay_numerator == '0);
			den_s1      <= den_eff;
			prod_s1     <= DVD_W'(lim_p1) * DVD_W'(chunk.delay_numerator);
			scaled_s1   <= DVD_W'(chunk.delay_numerator) * TICKS_PER_SEC;
		end
	end

	// The integer quotient den/num exceeds the limit exactly when den >= (limit+1)*num.
	always_comb begin
		too_fast = (cfg.max_rate_limit != '0) && (DVD_W'(den_s1) >= prod_s1);
		use_fallback = num_zero_s1 || too_fast;
		if (use_fallback) begin
			divisor_c  = cfg.fallback_rate;
			dividend_c = TICKS_PER_SEC + DVD_W'(cfg.fallback_rate >> 1);
		end else begin
			divisor_c  = den_s1;
			dividend_c = scaled_s1 + DVD_W'(den_s1 >> 1);
		end
	end

	// Second stage: the first word of the divider chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			word_s2.status    <= invalid_s1 ? STATUS_BAD : STATUS_OK;
			word_s2.key_frame <= key_s1 && !invalid_s1;
			word_s2.div_zero  <= (divisor_c == '0);
			word_s2.divisor   <= divisor_c;
			word_s2.rem       <= '0;
			word_s2.dvd       <= dividend_c;
			word_s2.quot      <= '0;
		end
	end

	assign down_valid = v_s2;
	assign down_word  = word_s2;

endmodule

>>> rtl/core/fctl_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit of the
// word it holds and hands the word on to its neighbor.
// Depends on fctl_pkg.
module fctl_div_cell import fctl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	input  div_word_t up_word,
	output logic      up_ready,
	output logic      down_valid,
	output div_word_t down_word,
	input  logic      down_ready
);

	logic [DELAY_W:0] cand;
	logic [DELAY_W:0] diff;
	logic             ge;
	div_word_t        next_word;
	logic             v_q;
	div_word_t        word_q;

	assign up_ready = !v_q || down_ready;

	// Bring down the next dividend bit and subtract when it fits.
	always_comb begin
		cand = {up_word.rem, up_word.dvd[DVD_W-1]};
		diff = cand - {1'b0, up_word.divisor};
		ge   = (cand >= {1'b0, up_word.divisor});
		next_word      = up_word;
		next_word.rem  = ge ? diff[DELAY_W-1:0] : cand[DELAY_W-1:0];
		next_word.dvd  = {up_word.dvd[DVD_W-2:0], 1'b0};
		next_word.quot = {up_word.quot[QUOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= next_word;
		end
	end

	assign down_valid = v_q;
	assign down_word  = word_q;

	// The partial remainder always stays below a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !word_q.div_zero |-> word_q.rem < word_q.divisor)
		else $error("fctl_div_cell: remainder not below divisor");

endmodule

>>> rtl/core/apng_frame_control_decoder_unit.sv
// APNG frame-control decoder, top level.
// Depends on fctl_pkg, fctl_chunk_if, fctl_result_if, fctl_front, fctl_div_cell.
//
// Usage: the chunk channel carries the parsed fields of one frame-control
// chunk per word; the result channel returns one word per chunk with the
// status, the key-frame flag and the duration in 1/100000 s ticks. Both
// channels move a word at a clock edge where valid and ready are high.
// The canvas size, the rate limit and the fallback rate are set through
// the write port (wr_en, wr_index, wr_data) while no chunk is in flight.
//
// An accepted chunk passes two front stages, one cell per quotient bit
// in a 33-cell divider chain, and the result register. While the
// receiver takes results, the chain takes one word every cycle, so a new
// chunk can be accepted each cycle. When the receiver stalls, the words
// close up behind the result register and the chunk channel drops ready
// only once every stage holds a word. Reset clears all valid bits and
// loads the register reset values; no results are pending afterwards.
module apng_frame_control_decoder_unit import fctl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [DIM_W-1:0]     wr_data,
	fctl_chunk_if.sink           chunk,
	fctl_result_if.source        result
);

	cfg_t      cfg_q;
	logic      link_valid [0:QUOT_W];
	logic      link_ready [0:QUOT_W];
	div_word_t link_word  [0:QUOT_W];

	logic             out_v_q;
	logic             status_q;
	logic             key_q;
	logic [DIM_W-1:0] dur_q;
	logic [DIM_W-1:0] dur_c;
	div_word_t        last_word;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= '0;
			cfg_q.image_height   <= '0;
			cfg_q.max_rate_limit <= '0;
			cfg_q.fallback_rate  <= FALLBACK_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_IMAGE_WIDTH:  cfg_q.image_width    <= wr_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height   <= wr_data;
				REG_MAX_RATE:     cfg_q.max_rate_limit <= wr_data[RATE_W-1:0];
				REG_FALLBACK:     cfg_q.fallback_rate  <= wr_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Verdict and division setup.
	fctl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.chunk      (chunk),
		.down_valid (link_valid[0]),
		.down_word  (link_word[0]),
		.down_ready (link_ready[0])
	);

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
		fctl_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (link_valid[i]),
			.up_word    (link_word[i]),
			.up_ready   (link_ready[i]),
			.down_valid (link_valid[i+1]),
			.down_word  (link_word[i+1]),
			.down_ready (link_ready[i+1])
		);
	end

	assign link_ready[QUOT_W] = !out_v_q || result.ready;
	assign last_word = link_word[QUOT_W];

	// Saturate the quotient; a zero divisor or a bad frame gives zero.
	always_comb begin
		if (last_word.status == STATUS_BAD || last_word.div_zero) begin
			dur_c = '0;
		end else if (last_word.quot[QUOT_W-1:DIM_W] != '0) begin
			dur_c = DURATION_MAX;
		end else begin
			dur_c = last_word.quot[DIM_W-1:0];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (link_ready[QUOT_W]) begin
			out_v_q <= link_valid[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (link_ready[QUOT_W] && link_valid[QUOT_W]) begin
			status_q <= last_word.status;
			key_q    <= last_word.key_frame;
			dur_q    <= dur_c;
		end
	end

	assign result.valid          = out_v_q;
	assign result.status         = status_q;
	assign result.key_frame      = key_q;
	assign result.duration_ticks = dur_q;

	// A rejected frame carries neither key flag nor duration.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == STATUS_BAD |->
			!result.key_frame && result.duration_ticks == '0)
		else $error("apng_frame_control_decoder_unit: bad frame with nonzero fields");

	// With the result register empty, no stage can be blocking the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> chunk.ready)
		else $error("apng_frame_control_decoder_unit: input stalled with empty output");

	// A key frame is always an accepted frame, also at the chain's end.
	assert property (@(posedge clk) disable iff (!arst_n)
		link_valid[QUOT_W] && last_word.key_frame |-> last_word.status == STATUS_OK)
		else $error("apng_frame_control_decoder_unit: key flag on rejected frame");

endmodule
